[sv/sia_pkg.sv]
// ----------------------------------------------------------------------------
// sia_pkg: shared types, constants and helpers for the saturating interval ALU
// Holds the transaction structs, operation codes and the divider step.
// ----------------------------------------------------------------------------
package sia_pkg;

	localparam int DW        = 32;
	localparam int DIV_STEPS = DW;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_NEG = 3'd3;
	localparam logic [2:0] FN_DIV = 3'd4;
	localparam logic [2:0] FN_MOD = 3'd5;

	localparam logic signed [DW-1:0] I32_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] I32_MAX = {1'b0, {(DW-1){1'b1}}};

	typedef struct packed {
		logic [2:0]             func;
		logic signed [DW-1:0]   a_min;
		logic signed [DW-1:0]   a_max;
		logic                   a_known;
		logic                   a_tainted;
		logic signed [DW-1:0]   b_min;
		logic signed [DW-1:0]   b_max;
		logic                   b_known;
		logic                   b_tainted;
	} op_t;

	typedef struct packed {
		logic signed [DW-1:0]   res_min;
		logic signed [DW-1:0]   res_max;
		logic                   res_known;
		logic                   res_tainted;
	} res_t;

	// Divider state: four lanes (amin/bmin, amin/bmax, amax/bmin, amax/bmax).
	typedef struct packed {
		op_t                    op;
		logic [3:0][DW-1:0]     n;
		logic [3:0][DW-1:0]     r;
		logic [1:0][DW-1:0]     d;
		logic [3:0]             qneg;
	} div_t;

	typedef struct packed {
		logic                   known;
		logic                   taint;
		logic                   span;
		logic signed [DW-1:0]   lo;
		logic signed [DW-1:0]   hi;
	} flg_t;

	typedef struct packed {
		flg_t                      f;
		logic [3:0][2*DW-1:0]      v;
	} prd_t;

	typedef struct packed {
		flg_t                   f;
		logic signed [2*DW-1:0] lo01;
		logic signed [2*DW-1:0] hi01;
		logic signed [2*DW-1:0] lo23;
		logic signed [2*DW-1:0] hi23;
	} mm_t;

	function automatic logic [DW-1:0] abs32(logic signed [DW-1:0] x);
		abs32 = x[DW-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic signed [DW-1:0] sat64(logic signed [2*DW-1:0] x);
		logic signed [2*DW-1:0] mn;
		logic signed [2*DW-1:0] mx;
		mn = {{DW{1'b1}}, I32_MIN};
		mx = {{DW{1'b0}}, I32_MAX};
		if (x < mn)
			sat64 = I32_MIN;
		else if (x > mx)
			sat64 = I32_MAX;
		else
			sat64 = x[DW-1:0];
	endfunction

	// One restoring division step on every lane.
	function automatic div_t div_step(div_t x);
		div_t           y;
		logic [DW-1:0]  rs;
		logic [DW-1:0]  dv;
		logic           ge;
		y = x;
		for (int l = 0; l < 4; l++) begin
			dv = x.d[l % 2];
			rs = {x.r[l][DW-2:0], x.n[l][DW-1]};
			ge = (rs >= dv);
			y.r[l] = ge ? (rs - dv) : rs;
			y.n[l] = {x.n[l][DW-2:0], ge};
		end
		div_step = y;
	endfunction

endpackage

[sv/saturating_interval_alu_top.sv]
// ----------------------------------------------------------------------------
// saturating_interval_alu_top: pipelined saturating interval ALU
// Add, subtract, multiply, negate and divide on signed 32-bit intervals; modulo gives an unknown result.
// ----------------------------------------------------------------------------
//
// Channel  Signals                       Struct  Moves
// op       op_valid, op_ready, op        op_t    one operation per transaction
// res      res_valid, res_ready, res     res_t   one result per transaction
//
// Every operation passes through 36 register stages, whatever its function,
// and one operation can be accepted every cycle while the skid register is
// free. The stages are the entry register, the 32-stage bit-serial divider
// pipeline, a multiply stage, a pairwise min/max stage and the final min/max
// and saturation stage.
// Reset clears all valid bits and the full flag of the output skid register.
// A stall on the result side first fills a one-entry skid register; only
// when that is full does the whole pipeline hold, so nothing is lost or
// repeated.
module saturating_interval_alu_top
	import sia_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int NST = DIV_STEPS + 4;

	logic [NST-1:0] vld_s;
	div_t           dv_s [0:DIV_STEPS];
	prd_t           pr_s34;
	mm_t            mm_s35;
	res_t           rs_s36;
	res_t           skid_q;
	logic           skid_full_q;
	logic           en;
	div_t           dv_in;

	// The whole pipeline moves together while the skid register is free.
	assign en       = !skid_full_q;
	assign op_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], op_valid};
		end
	end

	// Entry stage: operand magnitudes feed the dividers, signs give the
	// quotient sign for each lane.
	always_comb begin
		dv_in      = '0;
		dv_in.op   = op;
		dv_in.n[0] = abs32(op.a_min);
		dv_in.n[1] = abs32(op.a_min);
		dv_in.n[2] = abs32(op.a_max);
		dv_in.n[3] = abs32(op.a_max);
		dv_in.d[0] = abs32(op.b_min);
		dv_in.d[1] = abs32(op.b_max);
		dv_in.qneg[0] = op.a_min[DW-1] ^ op.b_min[DW-1];
		dv_in.qneg[1] = op.a_min[DW-1] ^ op.b_max[DW-1];
		dv_in.qneg[2] = op.a_max[DW-1] ^ op.b_min[DW-1];
		dv_in.qneg[3] = op.a_max[DW-1] ^ op.b_max[DW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dv_in;
		end
	end

	// One quotient bit per stage on all four lanes.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= div_step(dv_s[k-1]);
			end
		end
	end

	// Multiply stage: the four endpoint products or the signed quotients,
	// together with the decode of known, taint and the simple operations.
	op_t                    o;
	prd_t                   pr_d;
	logic                   zdiv;
	logic signed [DW+1:0]   sum_lo;
	logic signed [DW+1:0]   sum_hi;
	logic signed [DW:0]     q;

	always_comb begin
		o      = dv_s[DIV_STEPS].op;
		pr_d   = '0;
		zdiv   = (o.b_min <= 0 && o.b_max >= 0) || o.b_min == 0 || o.b_max == 0;
		sum_lo = '0;
		sum_hi = '0;
		q      = '0;
		if (o.func == FN_SUB) begin
			sum_lo = {{2{o.a_min[DW-1]}}, o.a_min} - {{2{o.b_max[DW-1]}}, o.b_max};
			sum_hi = {{2{o.a_max[DW-1]}}, o.a_max} - {{2{o.b_min[DW-1]}}, o.b_min};
		end else begin
			sum_lo = {{2{o.a_min[DW-1]}}, o.a_min} + {{2{o.b_min[DW-1]}}, o.b_min};
			sum_hi = {{2{o.a_max[DW-1]}}, o.a_max} + {{2{o.b_max[DW-1]}}, o.b_max};
		end
		if (o.func == FN_NEG) begin
			pr_d.f.known = o.a_known;
			pr_d.f.taint = o.a_known & o.a_tainted;
			pr_d.f.lo    = (o.a_max == I32_MIN) ? I32_MIN : -o.a_max;
			pr_d.f.hi    = (o.a_min == I32_MIN) ? I32_MAX : -o.a_min;
		end else if (o.func <= FN_MOD && o.a_known && o.b_known) begin
			pr_d.f.taint = o.a_tainted | o.b_tainted;
			pr_d.f.lo    = sat64({{(DW-2){sum_lo[DW+1]}}, sum_lo});
			pr_d.f.hi    = sat64({{(DW-2){sum_hi[DW+1]}}, sum_hi});
			pr_d.f.known = (o.func == FN_ADD) || (o.func == FN_SUB) ||
				(o.func == FN_MUL) || (o.func == FN_DIV && !zdiv);
			pr_d.f.span  = (o.func == FN_MUL) || (o.func == FN_DIV);
		end
		for (int l = 0; l < 4; l++) begin
			q = dv_s[DIV_STEPS].qneg[l] ? -$signed({1'b0, dv_s[DIV_STEPS].n[l]})
				: $signed({1'b0, dv_s[DIV_STEPS].n[l]});
			pr_d.v[l] = {{(DW-1){q[DW]}}, q};
		end
		if (o.func == FN_MUL) begin
			pr_d.v[0] = o.a_min * o.b_min;
			pr_d.v[1] = o.a_min * o.b_max;
			pr_d.v[2] = o.a_max * o.b_min;
			pr_d.v[3] = o.a_max * o.b_max;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s34 <= pr_d;
		end
	end

	// Pairwise minimum and maximum.
	logic signed [2*DW-1:0] v0, v1, v2, v3;
	assign v0 = pr_s34.v[0];
	assign v1 = pr_s34.v[1];
	assign v2 = pr_s34.v[2];
	assign v3 = pr_s34.v[3];

	always_ff @(posedge clk) begin
		if (en) begin
			mm_s35.f    <= pr_s34.f;
			mm_s35.lo01 <= (v1 < v0) ? v1 : v0;
			mm_s35.hi01 <= (v1 > v0) ? v1 : v0;
			mm_s35.lo23 <= (v3 < v2) ? v3 : v2;
			mm_s35.hi23 <= (v3 > v2) ? v3 : v2;
		end
	end

	// Final span, saturation, and zeroed bounds for an unknown result.
	res_t rs_d;
	always_comb begin
		rs_d.res_known   = mm_s35.f.known;
		rs_d.res_tainted = mm_s35.f.taint;
		rs_d.res_min     = mm_s35.f.lo;
		rs_d.res_max     = mm_s35.f.hi;
		if (mm_s35.f.span) begin
			rs_d.res_min = sat64((mm_s35.lo23 < mm_s35.lo01) ? mm_s35.lo23 : mm_s35.lo01);
			rs_d.res_max = sat64((mm_s35.hi23 > mm_s35.hi01) ? mm_s35.hi23 : mm_s35.hi01);
		end
		if (!mm_s35.f.known) begin
			rs_d.res_min = '0;
			rs_d.res_max = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s36 <= rs_d;
		end
	end

	// Skid register: catches the last stage's result when it is not taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (res_ready) skid_full_q <= 1'b0;
		end else if (vld_s[NST-1] && !res_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_q <= rs_s36;
		end
	end

	assign res_valid = skid_full_q | vld_s[NST-1];
	assign res       = skid_full_q ? skid_q : rs_s36;

endmodule

[sv/sia_checker.sv]
// ----------------------------------------------------------------------------
// sia_checker: port-level assertions for the saturating interval ALU
// Checks the result handshake, basic properties of result transactions and op_ready.
// ----------------------------------------------------------------------------
module sia_checker
	import sia_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic op_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.res_known |-> res.res_min == 0 && res.res_max == 0)
		else $error("unknown result with nonzero bounds");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> op_ready)
		else $error("input stalled with an empty output");

	a_ready_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> op_ready)
		else $error("input stalled after the output drained");

endmodule

bind saturating_interval_alu_top sia_checker u_sia_checker (.*);
